// ===== hw/rtl/ssl_pkg.sv =====
// Shared types, sizes and codes for the sorted score list.
package ssl_pkg;

   localparam int CAPACITY = 32;
   localparam int ID_BITS  = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // command codes
   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_CLEAR  = 3'd2;
   localparam logic [2:0] CMD_UPDATE = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   // result status codes
   localparam logic [2:0] STS_DONE     = 3'd0;
   localparam logic [2:0] STS_FULL     = 3'd1;
   localparam logic [2:0] STS_NOTFOUND = 3'd2;
   localparam logic [2:0] STS_ENTRY    = 3'd3;
   localparam logic [2:0] STS_EMPTY    = 3'd4;

   typedef struct packed {
      logic [2:0]         command;
      logic [15:0]        entry_id;
      logic signed [31:0] score_in;
      logic signed [31:0] cand_a;
      logic signed [31:0] cand_b;
      logic signed [31:0] post_self;
      logic signed [31:0] post_next;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [15:0]        out_id;
      logic signed [31:0] out_score;
      logic [5:0]         out_count;
      logic               last;
   } rsp_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SUM,
      OP_REMOVE,
      OP_INSERT,
      OP_CLEAR,
      OP_REPLY,
      OP_READ
   } ssl_op_type;

   typedef struct packed {
      ssl_op_type op;
      logic       emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rd_last;
   } dp_stat_type;

endpackage

// ===== hw/rtl/ssl_dp.sv =====
// Datapath: sorted cell array, update adder, read-out index and result register.
module ssl_dp import ssl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output rsp_type      rsp_data
);

   logic [ID_BITS-1:0] cell_id_ff    [CAPACITY];
   logic [ID_BITS-1:0] cell_id_in    [CAPACITY];
   logic signed [31:0] cell_score_ff [CAPACITY];
   logic signed [31:0] cell_score_in [CAPACITY];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic signed [31:0] score_ff, score_in;
   logic signed [32:0] ab_ff, ab_in;
   logic signed [32:0] pp_ff, pp_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CAPACITY-1:0] live, lt, hit, hit_upto;
   logic                found, full, rd_last;
   logic signed [33:0]  diff;
   logic signed [31:0]  sat_sum;

   // per-cell compares, all cells in parallel
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         live[k] = CNT_W'(k) < count_ff;
         lt[k]   = live[k] && (cell_score_ff[k] < score_ff);
         hit[k]  = live[k] && (cell_id_ff[k] == id_ff);
      end
      hit_upto[0] = hit[0];
      for (int k = 1; k < CAPACITY; k++) begin
         hit_upto[k] = hit_upto[k-1] | hit[k];
      end
   end

   assign found   = hit_upto[CAPACITY-1];
   assign full    = count_ff == CNT_W'(CAPACITY);
   assign rd_last = (count_ff == '0) || ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);
   assign stat.rd_last = rd_last;

   // saturate a+b-(p0+p1) to 32 bits
   assign diff = 34'(ab_ff) - 34'(pp_ff);
   always_comb begin
      if (diff[33:31] != 3'b000 && diff[33:31] != 3'b111) begin
         sat_sum = diff[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         sat_sum = diff[31:0];
      end
   end

   always_comb begin
      cell_id_in    = cell_id_ff;
      cell_score_in = cell_score_ff;
      count_in      = count_ff;
      id_in         = id_ff;
      score_in      = score_ff;
      ab_in         = ab_ff;
      pp_in         = pp_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_in        = rsp_ff;
      case (cmd.op)
         OP_LOAD: begin
            id_in     = ID_BITS'(req_data.entry_id);
            score_in  = req_data.score_in;
            ab_in     = 33'(req_data.cand_a) + 33'(req_data.cand_b);
            pp_in     = 33'(req_data.post_self) + 33'(req_data.post_next);
            rd_idx_in = '0;
         end
         OP_SUM: begin
            score_in = sat_sum;
         end
         OP_REMOVE: begin
            if (found) begin
               // close the gap: every cell from the first hit on takes its upper neighbour
               for (int k = 0; k < CAPACITY - 1; k++) begin
                  if (hit_upto[k]) begin
                     cell_id_in[k]    = cell_id_ff[k+1];
                     cell_score_in[k] = cell_score_ff[k+1];
                  end
               end
               count_in = count_ff - CNT_W'(1);
            end
            if (cmd.emit) begin
               rsp_in.status    = found ? STS_DONE : STS_NOTFOUND;
               rsp_in.out_id    = '0;
               rsp_in.out_score = '0;
               rsp_in.out_count = 6'(count_in);
               rsp_in.last      = 1'b1;
            end
         end
         OP_INSERT: begin
            if (!full) begin
               // lt is a prefix; the first cell not below the new score takes it
               if (!lt[0]) begin
                  cell_id_in[0]    = id_ff;
                  cell_score_in[0] = score_ff;
               end
               for (int k = 1; k < CAPACITY; k++) begin
                  if (!lt[k]) begin
                     if (lt[k-1]) begin
                        cell_id_in[k]    = id_ff;
                        cell_score_in[k] = score_ff;
                     end else begin
                        cell_id_in[k]    = cell_id_ff[k-1];
                        cell_score_in[k] = cell_score_ff[k-1];
                     end
                  end
               end
               count_in = count_ff + CNT_W'(1);
            end
            rsp_in.status    = full ? STS_FULL : STS_DONE;
            rsp_in.out_id    = 16'(id_ff);
            rsp_in.out_score = score_ff;
            rsp_in.out_count = 6'(count_in);
            rsp_in.last      = 1'b1;
         end
         OP_CLEAR: begin
            count_in         = '0;
            rsp_in.status    = STS_DONE;
            rsp_in.out_id    = '0;
            rsp_in.out_score = '0;
            rsp_in.out_count = '0;
            rsp_in.last      = 1'b1;
         end
         OP_REPLY: begin
            rsp_in.status    = STS_DONE;
            rsp_in.out_id    = '0;
            rsp_in.out_score = '0;
            rsp_in.out_count = 6'(count_ff);
            rsp_in.last      = 1'b1;
         end
         OP_READ: begin
            if (count_ff == '0) begin
               rsp_in.status    = STS_EMPTY;
               rsp_in.out_id    = '0;
               rsp_in.out_score = '0;
            end else begin
               rsp_in.status    = STS_ENTRY;
               rsp_in.out_id    = 16'(cell_id_ff[rd_idx_ff]);
               rsp_in.out_score = cell_score_ff[rd_idx_ff];
            end
            rsp_in.out_count = 6'(count_ff);
            rsp_in.last      = rd_last;
            rd_idx_in        = rd_idx_ff + IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_id_ff    <= cell_id_in;
      cell_score_ff <= cell_score_in;
      id_ff         <= id_in;
      score_ff      <= score_in;
      ab_ff         <= ab_in;
      pp_ff         <= pp_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/ssl_ctrl.sv =====
// Controller: command sequencing and result valid.
module ssl_ctrl import ssl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [2:0]   req_command,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_REMOVE,
      S_INSERT,
      S_SINGLE,
      S_READ
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           upd_ff, upd_in;
   logic           clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // result register can take a new transaction
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      upd_in       = upd_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_IDLE;
      cmd.emit     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               upd_in = req_command == CMD_UPDATE;
               clr_in = req_command == CMD_CLEAR;
               case (req_command)
                  CMD_INSERT: state_in = S_INSERT;
                  CMD_REMOVE: state_in = S_REMOVE;
                  CMD_UPDATE: state_in = S_SUM;
                  CMD_READ:   state_in = S_READ;
                  default:    state_in = S_SINGLE;
               endcase
            end
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_REMOVE;
         end
         S_REMOVE: begin
            if (upd_ff) begin
               cmd.op   = OP_REMOVE;
               state_in = S_INSERT;
            end else if (out_free) begin
               cmd.op       = OP_REMOVE;
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_INSERT: begin
            if (out_free) begin
               cmd.op       = OP_INSERT;
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SINGLE: begin
            if (out_free) begin
               cmd.op       = clr_ff ? OP_CLEAR : OP_REPLY;
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            if (out_free) begin
               cmd.op       = OP_READ;
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (stat.rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         upd_ff       <= 1'b0;
         clr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upd_ff       <= upd_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/sorted_score_list.sv =====
// Top level of the sorted score list: controller, datapath and checks.
//
//   channel   dir   handshake            payload
//   req_      in    req_valid/req_stall  req_data (ssl_pkg::req_type)
//   rsp_      out   rsp_valid/rsp_stall  rsp_data (ssl_pkg::rsp_type)
//
// Insert, remove, clear and unused codes pass through a latch step, then
// a step that compares and shifts all cells in parallel while writing
// the result register. Update adds the saturating sum and the remove as
// steps before the insert. Read out latches, then gives one result per
// held entry, one a cycle through the cell read mux while the result
// is not stalled; an empty list gives a single empty result.
// Synchronous reset empties the list; cell contents are not cleared.
// A stalled result holds the sequencer; a new request is taken while the
// last result of the previous one is still waiting.
module sorted_score_list import ssl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   ssl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   ssl_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // an accepted transaction always keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request port free right after accepting a transaction");

   // only read-out entries may be followed by more results
   a_not_last_is_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.status == STS_ENTRY))
      else $error("non-final result that is not a list entry");

   // held count never exceeds capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_count <= 6'(CAPACITY)))
      else $error("result count beyond capacity");

endmodule
